@@ rtl/maze_backtracker_generator_defines.svh @@
// Assertion macros used by the checker file mbg_checker.sv.
`ifndef MAZE_BACKTRACKER_GENERATOR_DEFINES_SVH
`define MAZE_BACKTRACKER_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define MBG_ASSERT_IMPL(NAME, CLK, RSTN, ANTE, CONS) \
	NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error("maze generator check failed");

// Next-cycle implication.
`define MBG_ASSERT_NEXT(NAME, CLK, RSTN, ANTE, CONS) \
	NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error("maze generator check failed");

`endif

@@ rtl/mbg_pkg.sv @@
`timescale 1ns / 1ps

package mbg_pkg;

	localparam int MAX_SIDE = 32;
	localparam int SIDE_W   = $clog2(MAX_SIDE);
	localparam int CFG_W    = SIDE_W + 1;
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int SP_W     = ADDR_W + 1;
	localparam int OP_W     = 2;
	localparam int EV_W     = 3;
	localparam int DIR_W    = 2;
	localparam int PICK_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(16);

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [EV_W-1:0] EV_STARTED   = 3'd0;
	localparam logic [EV_W-1:0] EV_CARVED    = 3'd1;
	localparam logic [EV_W-1:0] EV_BACKTRACK = 3'd2;
	localparam logic [EV_W-1:0] EV_FINISHED  = 3'd3;
	localparam logic [EV_W-1:0] EV_WALLS     = 3'd4;

	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

	typedef struct packed {
		logic capture;
		logic clr_en;
		logic stack_rd;
		logic nb_lo;
		logic nb_hi;
		logic start_set;
		logic query_rd;
		logic query_out;
		logic fin_out;
		logic step_commit;
	} mbg_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic sp_zero;
		logic out_free;
	} mbg_status_t;

	function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] r);
		logic [CFG_W-1:0] s;
		if (r == '0) begin
			s = CFG_W'(1);
		end else if (r > CFG_W'(MAX_SIDE)) begin
			s = CFG_W'(MAX_SIDE);
		end else begin
			s = r;
		end
		return s;
	endfunction

	function automatic logic [SIDE_W-1:0] clamp_coord(input logic [SIDE_W-1:0] v,
			input logic [CFG_W-1:0] size);
		logic [CFG_W-1:0] last;
		last = size - CFG_W'(1);
		if ({1'b0, v} >= size) begin
			return last[SIDE_W-1:0];
		end
		return v;
	endfunction

endpackage

@@ rtl/mbg_if.sv @@
`timescale 1ns / 1ps

interface mbg_req_if;
	import mbg_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [SIDE_W-1:0] cell_x;
	logic [SIDE_W-1:0] cell_y;
	logic [PICK_W-1:0] random_pick;

	modport source (output valid, opcode, cell_x, cell_y, random_pick, input ready);
	modport sink (input valid, opcode, cell_x, cell_y, random_pick, output ready);
endinterface

interface mbg_rsp_if;
	import mbg_pkg::*;
	logic              valid;
	logic              ready;
	logic [EV_W-1:0]   event_res;
	logic [SIDE_W-1:0] from_x;
	logic [SIDE_W-1:0] from_y;
	logic [SIDE_W-1:0] to_x;
	logic [SIDE_W-1:0] to_y;
	logic [DIR_W-1:0]  direction;
	logic [SP_W-1:0]   stack_depth;
	logic              right_wall;
	logic              bottom_wall;

	modport source (output valid, event_res, from_x, from_y, to_x, to_y, direction,
		stack_depth, right_wall, bottom_wall, input ready);
	modport sink (input valid, event_res, from_x, from_y, to_x, to_y, direction,
		stack_depth, right_wall, bottom_wall, output ready);
endinterface

@@ rtl/maze_backtracker_generator.sv @@
`timescale 1ns / 1ps
// channel | dir | payload
// req     | in  | opcode, cell_x, cell_y, random_pick
// rsp     | out | event_res, from_x, from_y, to_x, to_y, direction,
//         |     | stack_depth, right_wall, bottom_wall
// cfg     | in  | cfg_we, cfg_idx, cfg_wdata (write only)
//
// Step: stack read, then two visited-bit reads, then the result register. Query: wall read,
// then the result register. Start: the 1024-entry wall/visited clear sweep, then the
// result register. A new item is taken only once the last one has loaded its result.
// After reset a clear sweep of all 1024 entries runs with req.ready low.
// One output register: the next item is taken while a result waits; an item whose
// result is ready holds in its last state until the output register frees.

module maze_backtracker_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mbg_pkg::CFG_W-1:0]      cfg_wdata,
	mbg_req_if.sink                        req,
	mbg_rsp_if.source                      rsp
);
	import mbg_pkg::*;

	mbg_cmd_t    cmd;
	mbg_status_t status;
	logic        req_ready;

	assign req.ready = req_ready;

	mbg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req_ready),
		.status     (status),
		.cmd        (cmd)
	);

	mbg_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.req_cell_x      (req.cell_x),
		.req_cell_y      (req.cell_y),
		.req_random_pick (req.random_pick),
		.cmd             (cmd),
		.status          (status),
		.rsp             (rsp)
	);

endmodule

@@ rtl/mbg_ctrl.sv @@
`timescale 1ns / 1ps

module mbg_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [mbg_pkg::OP_W-1:0]  req_opcode,
	output logic                      req_ready,
	input  mbg_pkg::mbg_status_t      status,
	output mbg_pkg::mbg_cmd_t         cmd
);
	import mbg_pkg::*;

	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CLR  = 4'd2;
	localparam logic [3:0] S_SSET = 4'd3;
	localparam logic [3:0] S_QRD  = 4'd4;
	localparam logic [3:0] S_QOUT = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_TOP  = 4'd7;
	localparam logic [3:0] S_NB   = 4'd8;
	localparam logic [3:0] S_DEC  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					case (req_opcode)
						OP_START: state_d = S_CLR;
						OP_STEP: begin
							if (status.sp_zero) begin
								state_d = S_FIN;
							end else begin
								cmd.stack_rd = 1'b1;
								state_d = S_TOP;
							end
						end
						OP_QUERY: state_d = S_QRD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) begin
					state_d = S_SSET;
				end
			end
			S_SSET: begin
				if (status.out_free) begin
					cmd.start_set = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_QRD: begin
				cmd.query_rd = 1'b1;
				state_d = S_QOUT;
			end
			S_QOUT: begin
				if (status.out_free) begin
					cmd.query_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.fin_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TOP: begin
				cmd.nb_lo = 1'b1;
				state_d = S_NB;
			end
			S_NB: begin
				cmd.nb_hi = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (status.out_free) begin
					cmd.step_commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/mbg_datapath.sv @@
`timescale 1ns / 1ps

module mbg_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mbg_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [mbg_pkg::SIDE_W-1:0]     req_cell_x,
	input  logic [mbg_pkg::SIDE_W-1:0]     req_cell_y,
	input  logic [mbg_pkg::PICK_W-1:0]     req_random_pick,
	input  mbg_pkg::mbg_cmd_t              cmd,
	output mbg_pkg::mbg_status_t           status,
	mbg_rsp_if.source                      rsp
);
	import mbg_pkg::*;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [SIDE_W-1:0] x_q;
	logic [SIDE_W-1:0] y_q;
	logic [PICK_W-1:0] pick_q;
	logic [SP_W-1:0]   sp_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic              vis_mem [CELLS];
	logic              rw_mem  [CELLS];
	logic              bw_mem  [CELLS];
	logic [ADDR_W-1:0] stk_mem [CELLS];

	logic              vis_a_q;
	logic              vis_b_q;
	logic [1:0]        vis_lo_q;
	logic              rw_rd_q;
	logic              bw_rd_q;
	logic [ADDR_W-1:0] stk_rd_q;

	logic              rsp_valid_q;
	logic [EV_W-1:0]   ev_q;
	logic [SIDE_W-1:0] fx_q;
	logic [SIDE_W-1:0] fy_q;
	logic [SIDE_W-1:0] tx_q;
	logic [SIDE_W-1:0] ty_q;
	logic [DIR_W-1:0]  dir_q;
	logic [SP_W-1:0]   depth_q;
	logic              rw_q;
	logic              bw_q;

	logic [CFG_W-1:0]  w;
	logic [CFG_W-1:0]  h;
	logic [SIDE_W-1:0] cx;
	logic [SIDE_W-1:0] cy;
	logic [ADDR_W-1:0] c_addr;
	logic [SP_W-1:0]   sp_m1;
	logic [SIDE_W-1:0] top_x;
	logic [SIDE_W-1:0] top_y;
	logic [CFG_W-1:0]  nx6 [4];
	logic [CFG_W-1:0]  ny6 [4];
	logic [ADDR_W-1:0] nb_addr [4];
	logic [3:0]        inb;
	logic [3:0]        vis_all;
	logic [3:0]        cand;
	logic [2:0]        count;
	logic [PICK_W+2:0] prod;
	logic [1:0]        idx;
	logic [2:0]        k;
	logic [DIR_W-1:0]  d_sel;
	logic              carve;
	logic [ADDR_W-1:0] n_addr;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic              sp_full;
	logic [SP_W-1:0]   step_sp_next;
	logic              load;

	logic [EV_W-1:0]   ev_d;
	logic [SIDE_W-1:0] fx_d;
	logic [SIDE_W-1:0] fy_d;
	logic [SIDE_W-1:0] tx_d;
	logic [SIDE_W-1:0] ty_d;
	logic [DIR_W-1:0]  dir_d;
	logic [SP_W-1:0]   depth_d;
	logic              rw_d;
	logic              bw_d;

	assign w      = eff_size(width_q);
	assign h      = eff_size(height_q);
	assign cx     = clamp_coord(x_q, w);
	assign cy     = clamp_coord(y_q, h);
	assign c_addr = {cy, cx};
	assign sp_m1  = sp_q - SP_W'(1);
	assign top_x  = stk_rd_q[SIDE_W-1:0];
	assign top_y  = stk_rd_q[ADDR_W-1:SIDE_W];

	always_comb begin
		nx6[0] = {1'b0, top_x} + CFG_W'(1);
		ny6[0] = {1'b0, top_y};
		nx6[1] = {1'b0, top_x} - CFG_W'(1);
		ny6[1] = {1'b0, top_y};
		nx6[2] = {1'b0, top_x};
		ny6[2] = {1'b0, top_y} + CFG_W'(1);
		nx6[3] = {1'b0, top_x};
		ny6[3] = {1'b0, top_y} - CFG_W'(1);
		for (int i = 0; i < 4; i++) begin
			inb[i]     = (nx6[i] < w) && (ny6[i] < h);
			nb_addr[i] = {ny6[i][SIDE_W-1:0], nx6[i][SIDE_W-1:0]};
		end
	end

	assign vis_all = {vis_b_q, vis_a_q, vis_lo_q};
	assign cand    = inb & ~vis_all;
	assign carve   = |cand;

	always_comb begin
		count = '0;
		for (int i = 0; i < 4; i++) begin
			count = count + {2'b00, cand[i]};
		end
	end

	assign prod = {3'b000, pick_q} * {{PICK_W{1'b0}}, count};
	assign idx  = prod[PICK_W+1:PICK_W];

	always_comb begin
		d_sel = DIR_RIGHT;
		k = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand[i]) begin
				if (k == {1'b0, idx}) begin
					d_sel = DIR_W'(i);
				end
				k = k + 3'd1;
			end
		end
	end

	assign n_addr       = nb_addr[d_sel];
	assign rd_addr_a    = cmd.nb_hi ? nb_addr[2] : nb_addr[0];
	assign rd_addr_b    = cmd.nb_hi ? nb_addr[3] : nb_addr[1];
	assign sp_full      = (sp_q == SP_W'(CELLS));
	assign step_sp_next = carve ? (sp_full ? sp_q : sp_q + SP_W'(1)) : sp_m1;

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			vis_mem[clr_cnt_q] <= 1'b0;
		end else if (cmd.start_set) begin
			vis_mem[c_addr] <= 1'b1;
		end else if (cmd.step_commit && carve) begin
			vis_mem[n_addr] <= 1'b1;
		end
		if (cmd.nb_lo || cmd.nb_hi) begin
			vis_a_q <= vis_mem[rd_addr_a];
			vis_b_q <= vis_mem[rd_addr_b];
		end
		if (cmd.nb_hi) begin
			vis_lo_q <= {vis_b_q, vis_a_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			rw_mem[clr_cnt_q] <= 1'b1;
		end else if (cmd.step_commit && carve && d_sel == DIR_RIGHT) begin
			rw_mem[stk_rd_q] <= 1'b0;
		end else if (cmd.step_commit && carve && d_sel == DIR_LEFT) begin
			rw_mem[n_addr] <= 1'b0;
		end
		if (cmd.query_rd) begin
			rw_rd_q <= rw_mem[c_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			bw_mem[clr_cnt_q] <= 1'b1;
		end else if (cmd.step_commit && carve && d_sel == DIR_DOWN) begin
			bw_mem[stk_rd_q] <= 1'b0;
		end else if (cmd.step_commit && carve && d_sel == DIR_UP) begin
			bw_mem[n_addr] <= 1'b0;
		end
		if (cmd.query_rd) begin
			bw_rd_q <= bw_mem[c_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_set) begin
			stk_mem[ADDR_W'(0)] <= c_addr;
		end else if (cmd.step_commit && carve && !sp_full) begin
			stk_mem[sp_q[ADDR_W-1:0]] <= n_addr;
		end
		if (cmd.stack_rd) begin
			stk_rd_q <= stk_mem[sp_m1[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= req_cell_x;
			y_q    <= req_cell_y;
			pick_q <= req_random_pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= GRID_RESET;
			height_q  <= GRID_RESET;
			sp_q      <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_IDX_WIDTH:  width_q <= cfg_wdata;
					CFG_IDX_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.clr_en) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			if (cmd.start_set) begin
				sp_q <= SP_W'(1);
			end else if (cmd.step_commit) begin
				sp_q <= step_sp_next;
			end
		end
	end

	assign load = cmd.start_set || cmd.query_out || cmd.fin_out || cmd.step_commit;

	always_comb begin
		ev_d    = EV_FINISHED;
		fx_d    = '0;
		fy_d    = '0;
		tx_d    = '0;
		ty_d    = '0;
		dir_d   = DIR_RIGHT;
		depth_d = sp_q;
		rw_d    = 1'b0;
		bw_d    = 1'b0;
		if (cmd.start_set) begin
			ev_d    = EV_STARTED;
			fx_d    = cx;
			fy_d    = cy;
			depth_d = SP_W'(1);
		end else if (cmd.query_out) begin
			ev_d = EV_WALLS;
			fx_d = cx;
			fy_d = cy;
			rw_d = rw_rd_q;
			bw_d = bw_rd_q;
		end else if (cmd.step_commit) begin
			fx_d    = top_x;
			fy_d    = top_y;
			depth_d = step_sp_next;
			if (carve) begin
				ev_d  = EV_CARVED;
				tx_d  = nx6[d_sel][SIDE_W-1:0];
				ty_d  = ny6[d_sel][SIDE_W-1:0];
				dir_d = d_sel;
			end else begin
				ev_d = EV_BACKTRACK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_q    <= ev_d;
			fx_q    <= fx_d;
			fy_q    <= fy_d;
			tx_q    <= tx_d;
			ty_q    <= ty_d;
			dir_q   <= dir_d;
			depth_q <= depth_d;
			rw_q    <= rw_d;
			bw_q    <= bw_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.event_res   = ev_q;
	assign rsp.from_x      = fx_q;
	assign rsp.from_y      = fy_q;
	assign rsp.to_x        = tx_q;
	assign rsp.to_y        = ty_q;
	assign rsp.direction   = dir_q;
	assign rsp.stack_depth = depth_q;
	assign rsp.right_wall  = rw_q;
	assign rsp.bottom_wall = bw_q;

	assign status.clr_last = (clr_cnt_q == ADDR_W'(CELLS - 1));
	assign status.sp_zero  = (sp_q == '0);
	assign status.out_free = !rsp_valid_q || rsp.ready;

endmodule

@@ rtl/mbg_checker.sv @@
`timescale 1ns / 1ps
`include "maze_backtracker_generator_defines.svh"

module mbg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [mbg_pkg::EV_W-1:0]    event_res,
	input logic [mbg_pkg::SIDE_W-1:0]  from_x,
	input logic [mbg_pkg::SIDE_W-1:0]  from_y,
	input logic [mbg_pkg::SIDE_W-1:0]  to_x,
	input logic [mbg_pkg::SIDE_W-1:0]  to_y,
	input logic [mbg_pkg::DIR_W-1:0]   direction,
	input logic [mbg_pkg::SP_W-1:0]    stack_depth
);
	import mbg_pkg::*;

	`MBG_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(event_res) && $stable(from_x) && $stable(from_y) && $stable(to_x) && $stable(to_y) && $stable(stack_depth))
	`MBG_ASSERT_IMPL(a_carve_adjacent, clk, arst_n, rsp_valid && event_res == EV_CARVED, (direction == DIR_RIGHT && to_x == from_x + 5'd1 && to_y == from_y) || (direction == DIR_LEFT && to_x == from_x - 5'd1 && to_y == from_y) || (direction == DIR_DOWN && to_y == from_y + 5'd1 && to_x == from_x) || (direction == DIR_UP && to_y == from_y - 5'd1 && to_x == from_x))
	`MBG_ASSERT_IMPL(a_finished_empty, clk, arst_n, rsp_valid && event_res == EV_FINISHED, stack_depth == '0 && from_x == '0 && from_y == '0)
	`MBG_ASSERT_IMPL(a_started_depth, clk, arst_n, rsp_valid && event_res == EV_STARTED, stack_depth == SP_W'(1))

endmodule

bind maze_backtracker_generator mbg_checker u_mbg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.event_res   (rsp.event_res),
	.from_x      (rsp.from_x),
	.from_y      (rsp.from_y),
	.to_x        (rsp.to_x),
	.to_y        (rsp.to_y),
	.direction   (rsp.direction),
	.stack_depth (rsp.stack_depth)
);

@@ dv/maze_backtracker_generator_test.sv @@
`timescale 1ns / 1ps

module maze_backtracker_generator_test;
	import mbg_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 10;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int PLAN_ROWS = 37;
	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
	localparam logic [DIR_W-1:0] SCAN_ORDER [4] = '{DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP};
	localparam int SCAN_DX [4] = '{1, -1, 0, 0};
	localparam int SCAN_DY [4] = '{0, 0, 1, -1};

	typedef struct packed {
		logic [EV_W-1:0]   ev;
		logic [SIDE_W-1:0] fx;
		logic [SIDE_W-1:0] fy;
		logic [SIDE_W-1:0] tx;
		logic [SIDE_W-1:0] ty;
		logic [DIR_W-1:0]  dir;
		logic [SP_W-1:0]   depth;
		logic              rw;
		logic              bw;
	} maze_ev_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [OP_W-1:0]      op;
		logic [SIDE_W-1:0]    x;
		logic [SIDE_W-1:0]    y;
		logic [PICK_W-1:0]    pick;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     val;
		maze_ev_t             want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	mbg_req_if req ();
	mbg_rsp_if rsp ();

	maze_backtracker_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	logic [CFG_W-1:0]  cols_reg;
	logic [CFG_W-1:0]  rows_reg;
	bit [CELLS-1:0]    carved_mask;
	bit [CELLS-1:0]    east_wall;
	bit [CELLS-1:0]    south_wall;
	logic [ADDR_W-1:0] trail [CELLS];
	int unsigned       trail_len;

	maze_ev_t    awaited_events [$];
	int unsigned mismatches = 0;
	int unsigned cycle_count;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		maze_ev_t got;
		maze_ev_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.event_res, rsp.from_x, rsp.from_y, rsp.to_x, rsp.to_y,
				rsp.direction, rsp.stack_depth, rsp.right_wall, rsp.bottom_wall};
			if (awaited_events.size() == 0) begin
				flag_mismatch("result with none pending", got.ev, 0);
			end else begin
				want = awaited_events.pop_front();
				if (got.ev !== want.ev) flag_mismatch("event_res", got.ev, want.ev);
				if (got.fx !== want.fx) flag_mismatch("from_x", got.fx, want.fx);
				if (got.fy !== want.fy) flag_mismatch("from_y", got.fy, want.fy);
				if (got.tx !== want.tx) flag_mismatch("to_x", got.tx, want.tx);
				if (got.ty !== want.ty) flag_mismatch("to_y", got.ty, want.ty);
				if (got.dir !== want.dir) flag_mismatch("direction", got.dir, want.dir);
				if (got.depth !== want.depth) flag_mismatch("stack_depth", got.depth, want.depth);
				if (got.rw !== want.rw) flag_mismatch("right_wall", got.rw, want.rw);
				if (got.bw !== want.bw) flag_mismatch("bottom_wall", got.bw, want.bw);
			end
		end
	end

	function automatic int unsigned side_in_use(input logic [CFG_W-1:0] r);
		if (r == 0) return 1;
		return (r > MAX_SIDE) ? MAX_SIDE : r;
	endfunction

	function automatic int unsigned pin_coord(input logic [SIDE_W-1:0] v,
			input int unsigned side);
		return (v >= side) ? side - 1 : v;
	endfunction

	function automatic maze_ev_t plain_ev(input logic [EV_W-1:0] code,
			input int unsigned fx, input int unsigned fy, input int unsigned depth,
			input bit rw, input bit bw);
		maze_ev_t e;
		e = '0;
		e.ev = code;
		e.fx = SIDE_W'(fx);
		e.fy = SIDE_W'(fy);
		e.depth = SP_W'(depth);
		e.rw = rw;
		e.bw = bw;
		return e;
	endfunction

	function automatic maze_ev_t carve_ev(input int unsigned fx, input int unsigned fy,
			input int unsigned tx, input int unsigned ty, input logic [DIR_W-1:0] dir,
			input int unsigned depth);
		maze_ev_t e;
		e = plain_ev(EV_CARVED, fx, fy, depth, 1'b0, 1'b0);
		e.tx = SIDE_W'(tx);
		e.ty = SIDE_W'(ty);
		e.dir = dir;
		return e;
	endfunction

	task automatic advance_maze(input logic [OP_W-1:0] op, input logic [SIDE_W-1:0] x,
			input logic [SIDE_W-1:0] y, input logic [PICK_W-1:0] pick,
			output bit emits, output maze_ev_t ev);
		int unsigned cols, rows, cx, cy, top, nxt, cnt, sel, i;
		int nx, ny;
		int unsigned opts [4];
		logic [DIR_W-1:0] dir;
		cols = side_in_use(cols_reg);
		rows = side_in_use(rows_reg);
		emits = 1'b1;
		ev = '0;
		case (op)
			OP_START: begin
				cx = pin_coord(x, cols);
				cy = pin_coord(y, rows);
				top = cy * MAX_SIDE + cx;
				carved_mask = '0;
				east_wall = '1;
				south_wall = '1;
				carved_mask[top] = 1'b1;
				trail[0] = ADDR_W'(top);
				trail_len = 1;
				ev = plain_ev(EV_STARTED, cx, cy, trail_len, 1'b0, 1'b0);
			end
			OP_STEP: begin
				if (trail_len == 0) begin
					ev = plain_ev(EV_FINISHED, 0, 0, 0, 1'b0, 1'b0);
				end else begin
					top = trail[trail_len - 1];
					cx = top % MAX_SIDE;
					cy = top / MAX_SIDE;
					cnt = 0;
					for (i = 0; i < 4; i++) begin
						nx = int'(cx) + SCAN_DX[i];
						ny = int'(cy) + SCAN_DY[i];
						if (nx >= 0 && ny >= 0 && nx < int'(cols) && ny < int'(rows) &&
								!carved_mask[ny * MAX_SIDE + nx]) begin
							opts[cnt] = i;
							cnt++;
						end
					end
					if (cnt != 0) begin
						sel = opts[(pick * cnt) >> 8];
						dir = SCAN_ORDER[sel];
						nxt = (int'(cy) + SCAN_DY[sel]) * MAX_SIDE + int'(cx) + SCAN_DX[sel];
						case (dir)
							DIR_RIGHT: east_wall[top] = 1'b0;
							DIR_DOWN:  south_wall[top] = 1'b0;
							DIR_LEFT:  east_wall[nxt] = 1'b0;
							DIR_UP:    south_wall[nxt] = 1'b0;
							default: ;
						endcase
						carved_mask[nxt] = 1'b1;
						if (trail_len < CELLS) begin
							trail[trail_len] = ADDR_W'(nxt);
							trail_len++;
						end
						ev = carve_ev(cx, cy, nxt % MAX_SIDE, nxt / MAX_SIDE, dir, trail_len);
					end else begin
						trail_len--;
						ev = plain_ev(EV_BACKTRACK, cx, cy, trail_len, 1'b0, 1'b0);
					end
				end
			end
			OP_QUERY: begin
				cx = pin_coord(x, cols);
				cy = pin_coord(y, rows);
				top = cy * MAX_SIDE + cx;
				ev = plain_ev(EV_WALLS, cx, cy, trail_len, east_wall[top], south_wall[top]);
			end
			default: begin
				emits = 1'b0;
			end
		endcase
	endtask

	task automatic send_item(input logic [OP_W-1:0] op, input logic [SIDE_W-1:0] x,
			input logic [SIDE_W-1:0] y, input logic [PICK_W-1:0] pick,
			input bit typed, input maze_ev_t want);
		bit emits;
		maze_ev_t ev;
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.cell_x <= x;
		req.cell_y <= y;
		req.random_pick <= pick;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		advance_maze(op, x, y, pick, emits, ev);
		if (emits) awaited_events.push_back(typed ? want : ev);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (awaited_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_WIDTH) cols_reg = val;
		else rows_reg = val;
	endtask

	function automatic plan_row_t typed_row(input logic [OP_W-1:0] op, input int unsigned x,
			input int unsigned y, input int unsigned pick, input maze_ev_t want);
		plan_row_t r;
		r = '0;
		r.kind = ROW_TYPED;
		r.op = op;
		r.x = SIDE_W'(x);
		r.y = SIDE_W'(y);
		r.pick = PICK_W'(pick);
		r.want = want;
		return r;
	endfunction

	function automatic plan_row_t item_row(input logic [OP_W-1:0] op, input int unsigned x,
			input int unsigned y, input int unsigned pick);
		plan_row_t r;
		r = typed_row(op, x, y, pick, '0);
		r.kind = ROW_ITEM;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input int unsigned val);
		plan_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.val = CFG_W'(val);
		return r;
	endfunction

	function automatic logic [SIDE_W-1:0] rand_coord(input logic [CFG_W-1:0] side);
		if ($urandom_range(99) < 70) return SIDE_W'($urandom_range(side_in_use(side) - 1, 0));
		return SIDE_W'($urandom_range(31, 0));
	endfunction

	function automatic logic [CFG_W-1:0] rand_side();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70) return CFG_W'($urandom_range(6, 1));
		if (r < 85) return CFG_W'($urandom_range(16, 1));
		if (r < 93) return CFG_W'($urandom_range(63, 0));
		return CFG_W'(MAX_SIDE);
	endfunction

	task automatic random_mazes(input int unsigned items, input int unsigned src_pct,
			input int unsigned snk_pct);
		int unsigned sent, budget, area, r, k;
		logic [CFG_W-1:0] w, h;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(99);
			w = rand_side();
			h = rand_side();
			if (r < 8) begin
				w = CFG_W'(MAX_SIDE);
				h = CFG_W'($urandom_range(3, 1));
			end else if (r < 14) begin
				w = CFG_W'($urandom_range(3, 1));
				h = CFG_W'(MAX_SIDE);
			end else if (r < 60) begin
				w = CFG_W'($urandom_range(6, 1));
				h = CFG_W'($urandom_range(6, 1));
			end
			set_size(CFG_IDX_WIDTH, w);
			set_size(CFG_IDX_HEIGHT, h);
			area = side_in_use(w) * side_in_use(h);
			budget = $urandom_range(2 * area + 2, area);
			if (budget > 160) budget = $urandom_range(160, 40);
			send_item(OP_START, rand_coord(w), rand_coord(h), PICK_W'($urandom), 1'b0, '0);
			sent++;
			for (k = 0; k < budget && sent < items; k++) begin
				r = $urandom_range(99);
				if (r < 8) begin
					send_item(OP_QUERY, rand_coord(cols_reg), rand_coord(rows_reg),
						PICK_W'($urandom), 1'b0, '0);
					sent++;
				end else if (r < 10) begin
					send_item(OP_IGNORED, SIDE_W'($urandom), SIDE_W'($urandom),
						PICK_W'($urandom), 1'b0, '0);
				end else if (r < 11) begin
					send_item(OP_START, rand_coord(cols_reg), rand_coord(rows_reg),
						PICK_W'($urandom), 1'b0, '0);
					sent++;
				end else if (r < 12) begin
					set_size(CFG_IDX_WIDTH, rand_side());
					set_size(CFG_IDX_HEIGHT, rand_side());
				end else begin
					send_item(OP_STEP, SIDE_W'($urandom), SIDE_W'($urandom),
						PICK_W'($urandom_range(255, 0)), 1'b0, '0);
					sent++;
				end
			end
			if ($urandom_range(99) < 5) drain_results();
		end
	endtask

	initial begin
		plan_row_t plan [PLAN_ROWS];
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_IDX_WIDTH;
		cfg_wdata <= GRID_RESET;
		req.valid <= 1'b0;
		req.opcode <= OP_STEP;
		req.cell_x <= '0;
		req.cell_y <= '0;
		req.random_pick <= '0;
		src_idle_pct = 6;
		snk_idle_pct = 71;
		cols_reg = GRID_RESET;
		rows_reg = GRID_RESET;
		carved_mask = '0;
		east_wall = '1;
		south_wall = '1;
		trail_len = 0;
		plan = '{
			typed_row(OP_STEP, 0, 0, 0, plain_ev(EV_FINISHED, 0, 0, 0, 1'b0, 1'b0)),
			typed_row(OP_QUERY, 31, 31, 0, plain_ev(EV_WALLS, 15, 15, 0, 1'b1, 1'b1)),
			item_row(OP_IGNORED, 31, 31, 255),
			cfg_row(CFG_IDX_WIDTH, 1),
			cfg_row(CFG_IDX_HEIGHT, 1),
			typed_row(OP_START, 9, 9, 0, plain_ev(EV_STARTED, 0, 0, 1, 1'b0, 1'b0)),
			typed_row(OP_STEP, 0, 0, 128, plain_ev(EV_BACKTRACK, 0, 0, 0, 1'b0, 1'b0)),
			typed_row(OP_STEP, 0, 0, 0, plain_ev(EV_FINISHED, 0, 0, 0, 1'b0, 1'b0)),
			typed_row(OP_QUERY, 31, 0, 0, plain_ev(EV_WALLS, 0, 0, 0, 1'b1, 1'b1)),
			cfg_row(CFG_IDX_WIDTH, 0),
			cfg_row(CFG_IDX_HEIGHT, 63),
			typed_row(OP_START, 31, 31, 0, plain_ev(EV_STARTED, 0, 31, 1, 1'b0, 1'b0)),
			typed_row(OP_STEP, 0, 0, 0, carve_ev(0, 31, 0, 30, DIR_UP, 2)),
			item_row(OP_STEP, 0, 0, 255),
			item_row(OP_QUERY, 0, 30, 0),
			cfg_row(CFG_IDX_WIDTH, 63),
			cfg_row(CFG_IDX_HEIGHT, 0),
			typed_row(OP_START, 31, 5, 0, plain_ev(EV_STARTED, 31, 0, 1, 1'b0, 1'b0)),
			item_row(OP_STEP, 0, 0, 200),
			item_row(OP_STEP, 0, 0, 255),
			item_row(OP_QUERY, 30, 0, 0),
			cfg_row(CFG_IDX_WIDTH, 3),
			cfg_row(CFG_IDX_HEIGHT, 2),
			item_row(OP_START, 1, 1, 0),
			item_row(OP_STEP, 0, 0, 0),
			item_row(OP_STEP, 0, 0, 85),
			item_row(OP_STEP, 0, 0, 170),
			item_row(OP_STEP, 0, 0, 255),
			cfg_row(CFG_IDX_WIDTH, 1),
			cfg_row(CFG_IDX_HEIGHT, 1),
			item_row(OP_STEP, 0, 0, 0),
			item_row(OP_STEP, 0, 0, 255),
			item_row(OP_QUERY, 2, 1, 0),
			cfg_row(CFG_IDX_WIDTH, 32),
			cfg_row(CFG_IDX_HEIGHT, 32),
			item_row(OP_START, 15, 20, 0),
			item_row(OP_STEP, 0, 0, 1)
		};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				set_size(plan[i].idx, plan[i].val);
			end else begin
				send_item(plan[i].op, plan[i].x, plan[i].y, plan[i].pick,
					plan[i].kind == ROW_TYPED, plan[i].want);
			end
		end
		drain_results();
		random_mazes(367, 6, 71);
		random_mazes(367, 71, 6);
		random_mazes(366, 0, 0);
		drain_results();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mbg_pkg.sv
rtl/mbg_if.sv
rtl/mbg_ctrl.sv
rtl/mbg_datapath.sv
rtl/maze_backtracker_generator.sv
rtl/mbg_checker.sv
dv/maze_backtracker_generator_test.sv
